### hdl/csvp_pkg.sv
// Package with the constants, codes and types of the CSV row field parser.
`timescale 1ns / 1ps

package csvp_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
  localparam int FI_W        = 6;

  localparam logic [7:0] SEP_RESET = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_QUOTED   = 2'd1,
    MODE_AFTER    = 2'd2,
    MODE_UNQUOTED = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic             quote_pending;
    logic             after_cr;
    logic             something_read;
    logic [CNT_W-1:0] column_count;
  } pstate_t;

  typedef struct packed {
    logic            char_valid;
    logic [7:0]      char_out;
    logic            discard_field;
    logic            field_end;
    logic [FI_W-1:0] field_index;
    logic            row_end;
    logic            column_overflow;
  } result_t;

endpackage

### hdl/csvp_ifs.sv
// Request channel interfaces of the CSV row field parser: input bytes and results.
`timescale 1ns / 1ps

interface csvp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface csvp_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_out;
  logic       discard_field;
  logic       field_end;
  logic [5:0] field_index;
  logic       row_end;
  logic       column_overflow;

  modport source (output valid, char_valid, char_out, discard_field, field_end,
                  field_index, row_end, column_overflow, input ready);
  modport sink   (input valid, char_valid, char_out, discard_field, field_end,
                  field_index, row_end, column_overflow, output ready);
endinterface

### hdl/csvp_step.sv
// Next-state and result logic for one input byte or end-of-input request.
`timescale 1ns / 1ps

module csvp_step
  import csvp_pkg::*;
(
  input  logic       [7:0] sep_i,
  input  logic             kind_i,
  input  logic       [7:0] byte_i,
  input  pstate_t          st_i,
  output pstate_t          st_o,
  output result_t          res_o,
  output logic             has_res_o
);

  typedef struct packed {
    pstate_t st;
    result_t r;
    logic    ok;
  } step_t;

  function automatic pstate_t new_row(input pstate_t s);
    pstate_t o;
    o                = s;
    o.mode           = MODE_START;
    o.quote_pending  = 1'b0;
    o.something_read = 1'b0;
    o.column_count   = '0;
    return o;
  endfunction

  // A field is only stored when something was read; past the column limit
  // the whole row is abandoned instead.
  function automatic step_t store_field(input step_t s);
    step_t o;
    o    = s;
    o.ok = 1'b1;
    if (s.st.something_read) begin
      if (s.st.column_count >= CNT_W'(MAX_COLUMNS)) begin
        o.r.column_overflow = 1'b1;
        o.r.row_end         = 1'b1;
        o.st                = new_row(o.st);
        o.ok                = 1'b0;
      end else begin
        o.r.field_end       = 1'b1;
        o.r.field_index     = FI_W'(s.st.column_count);
        o.st.column_count   = s.st.column_count + 1'b1;
        o.st.something_read = 1'b0;
      end
    end
    return o;
  endfunction

  function automatic step_t end_row(input step_t s);
    step_t o;
    o = store_field(s);
    if (o.ok) begin
      o.r.row_end = 1'b1;
      o.st        = new_row(o.st);
    end
    return o;
  endfunction

  function automatic step_t resolve_quote(input step_t s);
    step_t o;
    o                  = s;
    o.st.quote_pending = 1'b0;
    if (s.st.mode == MODE_UNQUOTED) begin
      o.r.discard_field = 1'b1;
      o.st.mode         = MODE_QUOTED;
    end else begin
      o.st.mode = MODE_AFTER;
    end
    return o;
  endfunction

  function automatic step_t emit(input step_t s, input logic [7:0] c);
    step_t o;
    o              = s;
    o.r.char_valid = 1'b1;
    o.r.char_out   = c;
    return o;
  endfunction

  // Tests run quote, separator, LF, CR so the first match wins when the
  // separator collides with one of the others.
  function automatic step_t take_byte(input step_t s, input logic [7:0] c,
                                      input logic [7:0] sep);
    step_t o;
    o = s;
    unique case (s.st.mode)
      MODE_START: begin
        o.st.something_read = 1'b1;
        priority if (c == CH_QUOTE) begin
          o.st.mode = MODE_QUOTED;
        end else if (c == sep) begin
          o = store_field(o);
        end else if (c == CH_LF) begin
          o = end_row(o);
        end else if (c == CH_CR) begin
          o = end_row(o);
          o.st.after_cr = 1'b1;
        end else begin
          o = emit(o, c);
          o.st.mode = MODE_UNQUOTED;
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          o.st.quote_pending = 1'b1;
        end else begin
          o = emit(o, c);
        end
      end
      MODE_AFTER: begin
        priority if (c == sep) begin
          o = store_field(o);
          if (o.ok) begin
            o.st.mode = MODE_START;
          end
        end else if (c == CH_LF) begin
          o = end_row(o);
        end else if (c == CH_CR) begin
          o = end_row(o);
          o.st.after_cr = 1'b1;
        end else begin
          o = s;
        end
      end
      MODE_UNQUOTED: begin
        priority if (c == CH_QUOTE) begin
          o.st.quote_pending = 1'b1;
        end else if (c == sep) begin
          o = store_field(o);
          if (o.ok) begin
            o.st.mode = MODE_START;
          end
        end else if (c == CH_LF) begin
          o = end_row(o);
        end else if (c == CH_CR) begin
          o = end_row(o);
          o.st.after_cr = 1'b1;
        end else begin
          o = emit(o, c);
        end
      end
    endcase
    return o;
  endfunction

  step_t s;
  logic  open_row;
  logic  skip;

  always_comb begin
    s        = '0;
    s.st     = st_i;
    open_row = st_i.something_read || (st_i.column_count != '0);
    skip     = 1'b0;
    if (kind_i == KIND_END) begin
      s.st.after_cr = 1'b0;
      if (s.st.quote_pending) begin
        s = resolve_quote(s);
      end
      if (open_row) begin
        s = end_row(s);
      end else begin
        s.st = new_row(s.st);
      end
    end else begin
      if (s.st.after_cr) begin
        s.st.after_cr = 1'b0;
        // An LF right after CR belongs to the same line break.
        skip = (byte_i == CH_LF);
      end
      if (!skip) begin
        if (s.st.quote_pending && (byte_i == CH_QUOTE)) begin
          s.st.quote_pending = 1'b0;
          s = emit(s, CH_QUOTE);
        end else begin
          if (s.st.quote_pending) begin
            s = resolve_quote(s);
          end
          s = take_byte(s, byte_i, sep_i);
        end
      end
    end
  end

  assign st_o      = s.st;
  assign res_o     = s.r;
  assign has_res_o = s.r.char_valid | s.r.discard_field | s.r.field_end |
                     s.r.row_end | s.r.column_overflow;

endmodule

### hdl/csv_row_field_parser_top.sv
// Top level of the CSV row field parser: input register, step logic, result register.
//
// Usage: text bytes arrive on in_ch as requests (kind 0 with data_byte, or
// kind 1 for end of input). Each request yields zero or one result request on
// out_ch: a character to append, a field discard, field end with its column,
// row end, or a column overflow that abandons the row.
// The separator byte is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle (not enforced by the block); it resets to a comma.
// Throughput is one byte per clock while out_ch does not stall: the parse state
// is updated by a single combinational step between the input and result registers.
// An accepted request waits in the input register; its result moves on into the
// result register, which drives out_ch, when that register is free or being taken.
// When out_ch stalls, the result register holds its request and the input
// register fills; in_ch.ready then drops until the receiver takes the result.
// Requests that cause no result pass through without using out_ch.
// Reset (rst_n low, synchronous) empties both registers, sets the separator
// to a comma and puts the parser at the start of a new row.
`timescale 1ns / 1ps

module csv_row_field_parser_top
  import csvp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  csvp_in_if.sink             in_ch,
  csvp_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  logic       [7:0] separator_r;
  logic             in_v_r;
  logic             in_v_nxt;
  logic             in_kind_r;
  logic       [7:0] in_byte_r;
  logic             out_v_r;
  logic             out_v_nxt;
  result_t          res_r;
  pstate_t          st_r;
  pstate_t          st_nxt;
  result_t          step_res;
  logic             step_has;
  logic             advance;
  logic             in_take;

  assign advance = in_v_r && (!out_v_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_v_r || advance;

  csvp_step u_step (
    .sep_i     (separator_r),
    .kind_i    (in_kind_r),
    .byte_i    (in_byte_r),
    .st_i      (st_r),
    .st_o      (st_nxt),
    .res_o     (step_res),
    .has_res_o (step_has)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = step_has;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      separator_r <= SEP_RESET;
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      st_r        <= '{mode: MODE_START, quote_pending: 1'b0, after_cr: 1'b0,
                       something_read: 1'b0, column_count: '0};
    end else begin
      if (cfg_we) begin
        separator_r <= cfg_wdata;
      end
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r <= in_ch.kind;
      in_byte_r <= in_ch.data_byte;
    end
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.char_valid      = res_r.char_valid;
  assign out_ch.char_out        = res_r.char_out;
  assign out_ch.discard_field   = res_r.discard_field;
  assign out_ch.field_end       = res_r.field_end;
  assign out_ch.field_index     = res_r.field_index;
  assign out_ch.row_end         = res_r.row_end;
  assign out_ch.column_overflow = res_r.column_overflow;

  // The column counter stops at the limit; a field past it abandons the row.
  a_col_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.column_count <= CNT_W'(MAX_COLUMNS))
    else $error("column count beyond the column limit");

  // A pending quote can only come from a quoted or an unquoted field.
  a_quote_mode: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.quote_pending |-> (st_r.mode == MODE_QUOTED || st_r.mode == MODE_UNQUOTED))
    else $error("pending quote outside a quoted or unquoted field");

  // A CR always closes the row, so the parser waits at field start.
  a_cr_start: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.after_cr |-> (st_r.mode == MODE_START && !st_r.something_read))
    else $error("after CR but not at the start of a row");

  // A result request always carries at least one event.
  a_res_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (res_r.char_valid || res_r.discard_field || res_r.field_end ||
                 res_r.row_end || res_r.column_overflow))
    else $error("empty result request");

  // Overflow abandons the row, it never ends a field.
  a_ovf_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.column_overflow) |-> (res_r.row_end && !res_r.field_end))
    else $error("column overflow without row end");

endmodule

### verif/tb_csv_row_field_parser_top.sv
// Self-checking testbench for the CSV row field parser top level.
`timescale 1ns / 1ps

module tb_csv_row_field_parser_top;
  import csvp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;

  typedef struct {
    logic       kind;
    logic [7:0] data;
  } text_req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  csvp_in_if  in_bus ();
  csvp_out_if out_bus ();

  csv_row_field_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  text_req_t   text_queue[$];
  result_t     parse_events_due[$];
  text_req_t   next_req;
  int          send_idle;
  int          recv_idle;
  int          fail_count;
  int          cycle_count;
  int          items_made;

  // Parser state as the block should hold it.
  mode_t       p_mode;
  logic        p_qpend;
  logic        p_after_cr;
  logic        p_read;
  int unsigned p_cols;
  logic [7:0]  p_sep;
  result_t     p_res;

  always #1 clk = ~clk;

  function automatic void row_restart();
    p_mode  = MODE_START;
    p_qpend = 1'b0;
    p_read  = 1'b0;
    p_cols  = 0;
  endfunction

  function automatic void put_char(logic [7:0] c);
    p_res.char_valid = 1'b1;
    p_res.char_out   = c;
  endfunction

  // Returns 0 when the row was abandoned because of too many columns.
  function automatic bit close_field();
    if (!p_read) return 1'b1;
    if (p_cols >= MAX_COLUMNS) begin
      p_res.column_overflow = 1'b1;
      p_res.row_end         = 1'b1;
      row_restart();
      return 1'b0;
    end
    p_res.field_end   = 1'b1;
    p_res.field_index = p_cols[5:0];
    p_cols++;
    p_read = 1'b0;
    return 1'b1;
  endfunction

  function automatic void close_row();
    if (close_field()) begin
      p_res.row_end = 1'b1;
      row_restart();
    end
  endfunction

  // A pending quote that is not followed by a second quote.
  function automatic void lone_quote();
    p_qpend = 1'b0;
    if (p_mode == MODE_UNQUOTED) begin
      p_res.discard_field = 1'b1;
      p_mode = MODE_QUOTED;
    end else begin
      p_mode = MODE_AFTER;
    end
  endfunction

  function automatic void take_text(logic [7:0] c);
    case (p_mode)
      MODE_START: begin
        p_read = 1'b1;
        if (c == CH_QUOTE) p_mode = MODE_QUOTED;
        else if (c == p_sep) void'(close_field());
        else if (c == CH_LF) close_row();
        else if (c == CH_CR) begin
          close_row();
          p_after_cr = 1'b1;
        end else begin
          put_char(c);
          p_mode = MODE_UNQUOTED;
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) p_qpend = 1'b1;
        else put_char(c);
      end
      MODE_AFTER: begin
        // Only separators and line ends matter after a closing quote.
        if (c == p_sep) begin
          if (close_field()) p_mode = MODE_START;
        end else if (c == CH_LF) close_row();
        else if (c == CH_CR) begin
          close_row();
          p_after_cr = 1'b1;
        end
      end
      default: begin
        if (c == CH_QUOTE) p_qpend = 1'b1;
        else if (c == p_sep) begin
          if (close_field()) p_mode = MODE_START;
        end else if (c == CH_LF) close_row();
        else if (c == CH_CR) begin
          close_row();
          p_after_cr = 1'b1;
        end else put_char(c);
      end
    endcase
  endfunction

  // Advances the parser by one request; returns 1 when it yields a result in p_res.
  function automatic bit parse_step(logic kind, logic [7:0] c);
    bit open_row;
    bit done;
    p_res = '0;
    done  = 1'b0;
    if (kind == KIND_END) begin
      open_row   = p_read || (p_cols > 0);
      p_after_cr = 1'b0;
      if (p_qpend) lone_quote();
      if (open_row) close_row();
      else row_restart();
    end else begin
      if (p_after_cr) begin
        p_after_cr = 1'b0;
        if (c == CH_LF) return 1'b0;
      end
      if (p_qpend) begin
        if (c == CH_QUOTE) begin
          p_qpend = 1'b0;
          put_char(CH_QUOTE);
          done = 1'b1;
        end else begin
          lone_quote();
        end
      end
      if (!done) take_text(c);
    end
    return p_res.char_valid | p_res.discard_field | p_res.field_end |
           p_res.row_end | p_res.column_overflow;
  endfunction

  function automatic void check_event();
    result_t got;
    result_t want;
    got.char_valid      = out_bus.char_valid;
    got.char_out        = out_bus.char_out;
    got.discard_field   = out_bus.discard_field;
    got.field_end       = out_bus.field_end;
    got.field_index     = out_bus.field_index;
    got.row_end         = out_bus.row_end;
    got.column_overflow = out_bus.column_overflow;
    if (parse_events_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result at %0t: cv=%0d ch=%02h disc=%0d fe=%0d fi=%0d re=%0d ov=%0d",
                 $time, got.char_valid, got.char_out, got.discard_field, got.field_end,
                 got.field_index, got.row_end, got.column_overflow);
      return;
    end
    want = parse_events_due.pop_front();
    if (got.char_valid !== want.char_valid || got.char_out !== want.char_out ||
        got.discard_field !== want.discard_field || got.field_end !== want.field_end ||
        got.field_index !== want.field_index || got.row_end !== want.row_end ||
        got.column_overflow !== want.column_overflow) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch at %0t: expected cv=%0d ch=%02h disc=%0d fe=%0d fi=%0d re=%0d ov=%0d",
                 $time, want.char_valid, want.char_out, want.discard_field, want.field_end,
                 want.field_index, want.row_end, want.column_overflow);
        $display("                 actual   cv=%0d ch=%02h disc=%0d fe=%0d fi=%0d re=%0d ov=%0d",
                 got.char_valid, got.char_out, got.discard_field, got.field_end,
                 got.field_index, got.row_end, got.column_overflow);
      end
    end
  endfunction

  // Driver: presents queued requests, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (parse_step(in_bus.kind, in_bus.data_byte)) parse_events_due.push_back(p_res);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          next_req = text_queue.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.kind      <= next_req.kind;
          in_bus.data_byte <= next_req.data;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with random back-pressure and checks them in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_event();
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("csv_row_field_parser_top verification failed");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] c);
    text_req_t r;
    r.kind = KIND_TEXT;
    r.data = c;
    text_queue.push_back(r);
    items_made++;
  endtask

  task automatic push_end();
    text_req_t r;
    r.kind = KIND_END;
    r.data = 8'($urandom_range(0, 255));
    text_queue.push_back(r);
    items_made++;
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(32, 126));
    end while (c == CH_QUOTE || c == p_sep || c == CH_LF || c == CH_CR);
    return c;
  endfunction

  task automatic push_field();
    int pick;
    int len;
    logic [7:0] c;
    pick = $urandom_range(0, 9);
    if (pick <= 1) return;
    if (pick <= 5) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 11))
          0: push_text("\"\"");
          1: push_byte(CH_QUOTE);
          default: push_byte(plain_byte());
        endcase
      end
    end else if (pick <= 8) begin
      push_byte(CH_QUOTE);
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE) push_byte(CH_QUOTE);
        push_byte(c);
      end
      push_byte(CH_QUOTE);
      // Text after the closing quote should be dropped.
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_byte(plain_byte());
      end
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_row_end();
    case ($urandom_range(0, 3))
      0: push_byte(CH_LF);
      1: push_byte(CH_CR);
      2: begin
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
      default: push_end();
    endcase
  endtask

  task automatic push_row(int n);
    for (int i = 0; i < n; i++) begin
      push_field();
      if (i < n - 1) push_byte(p_sep);
    end
    push_row_end();
  endtask

  // A row around the column limit, with short fields to keep it cheap.
  task automatic push_wide_row();
    int n;
    n = $urandom_range(MAX_COLUMNS - 2, MAX_COLUMNS + 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) push_byte(plain_byte());
      if (i < n - 1) push_byte(p_sep);
    end
    push_row_end();
  endtask

  task automatic push_noise();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) push_end();
      else push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_random(int count);
    int stop_at;
    stop_at = items_made + count;
    while (items_made < stop_at) begin
      case ($urandom_range(0, 39))
        0:       push_wide_row();
        1, 2, 3: push_noise();
        default: push_row($urandom_range(1, 5));
      endcase
    end
  endtask

  // Waits until every request has been taken and every result has come back.
  task automatic drain();
    while (text_queue.size() != 0 || in_bus.valid || parse_events_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_separator(logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    p_sep = v;
  endtask

  task automatic run_phase(logic [7:0] sep, int s_idle, int r_idle);
    set_separator(sep);
    send_idle = s_idle;
    recv_idle = r_idle;
    push_random(20);
    drain();
    push_random(20);
    drain();
  endtask

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 8'h00;
    in_bus.valid     = 1'b0;
    in_bus.kind      = KIND_TEXT;
    in_bus.data_byte = 8'h00;
    out_bus.ready    = 1'b0;
    fail_count       = 0;
    cycle_count      = 0;
    items_made       = 0;
    send_idle        = 7;
    recv_idle        = 71;
    p_sep            = SEP_RESET;
    p_after_cr       = 1'b0;
    row_restart();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests with the reset separator.
    push_byte(8'h00);
    push_text(",");
    push_byte(8'hFF);
    push_text("\n");
    push_text("\"x\"\"y\"z\r\n");
    push_text("ab\"c\"");
    push_end();
    push_text(",\n\n");
    push_text("x,");
    push_end();
    push_end();
    drain();

    set_separator(SEP_RESET);
    push_wide_row();
    push_random(20);
    drain();
    push_random(20);
    drain();

    run_phase(8'h00, 7, 71);
    run_phase(8'hFF, 7, 71);
    run_phase(CH_QUOTE, 71, 7);
    run_phase(CH_LF, 71, 7);
    run_phase(CH_CR, 71, 7);
    run_phase(8'h3B, 0, 0);
    run_phase(8'h09, 0, 0);
    run_phase(SEP_RESET, 0, 0);

    if (fail_count == 0 && parse_events_due.size() == 0) begin
      $display("csv_row_field_parser_top verification clean");
    end else begin
      $display("csv_row_field_parser_top verification failed");
    end
    $finish;
  end

endmodule

### csv_row_field_parser_top.f
hdl/csvp_pkg.sv
hdl/csvp_ifs.sv
hdl/csvp_step.sv
hdl/csv_row_field_parser_top.sv
verif/tb_csv_row_field_parser_top.sv
